// ===== hdl/aik_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the arm inverse kinematics block.
package aik_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;

    // CORDIC coordinate width: 32-bit inputs plus gain and sign headroom
    localparam int CW = 40;
    // Angle width: +-1024 degrees with FRAC_BITS fraction bits
    localparam int ZW = FRAC_BITS + 11;

    localparam int LEN_W      = 31;
    localparam int ISQ_STEPS  = 32;
    localparam int FRONT_LAT  = 3;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int TOTAL_LAT  = FRONT_LAT + ISQ_STEPS + CORDIC_LAT + 1;

    localparam logic signed [ZW-1:0] DEG90  = ZW'(longint'(90)  <<< FRAC_BITS);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(longint'(180) <<< FRAC_BITS);

    localparam logic [LEN_W-1:0] SEG_LENGTH_RESET = LEN_W'(65536);
    localparam logic [7:0]       SHOULDER_BASE    = 8'd170;
    localparam logic [8:0]       ELBOW_BASE       = 9'd120;

    localparam int TBL_SH = (FRAC_BITS < 24) ? (24 - FRAC_BITS) : 0;

    localparam longint ATAN_Q24 [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 fixed;
        logic signed [ZW-1:0] fixval;
    } cordic_st_t;

    // atan(2^-idx) in degrees, rounded half up to FRAC_BITS fraction bits
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        longint t;
        longint r;
        t = ATAN_Q24[idx];
        if (TBL_SH == 0) begin
            r = t;
        end else begin
            r = (t + (longint'(1) <<< (TBL_SH - 1))) >>> TBL_SH;
        end
        return r[ZW-1:0];
    endfunction

endpackage

// ===== hdl/arm_inverse_kinematics_top.sv =====
// Pipeline order: front stages, square root, CORDIC, output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits
// at the output register and m_ready is low.
// Reset: aresetn (synchronous, active low) empties the pipeline and sets
// the segment length to 1.0 m (65536).
// Top level of the planar two-link arm inverse kinematics block.
module arm_inverse_kinematics_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [aik_pkg::LEN_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_target_x,
    input  logic signed [31:0]            s_target_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [8:0]                    m_base_angle,
    output logic [7:0]                    m_shoulder_command,
    output logic [8:0]                    m_elbow_command,
    output logic                          m_out_of_reach
);

    localparam int ZB_DLY  = aik_pkg::ISQ_STEPS;
    localparam int FAR_DLY = aik_pkg::ISQ_STEPS + aik_pkg::CORDIC_LAT;
    localparam int LAT     = aik_pkg::TOTAL_LAT;

    logic adv;
    logic [aik_pkg::LEN_W-1:0] seg_length_reg;
    logic vld_reg [LAT];

    logic signed [31:0] fx, fy;
    logic [63:0] fs, fd;
    logic        ffar;
    logic [31:0] adj, opp;
    logic signed [aik_pkg::ZW-1:0] zb, zt;

    logic signed [aik_pkg::ZW-1:0] zb_dly_reg [ZB_DLY];
    logic far_dly_reg [FAR_DLY];

    logic signed [aik_pkg::ZW-1:0] theta;
    logic signed [aik_pkg::ZW-1:0] base_full;
    logic signed [aik_pkg::ZW-1:0] elbow_full;

    logic [8:0] base_angle_reg;
    logic [7:0] shoulder_reg;
    logic [8:0] elbow_reg;
    logic       far_reg;

    // advance everything unless a result waits untaken
    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_length_reg <= aik_pkg::SEG_LENGTH_RESET;
        end else if (cfg_we) begin
            seg_length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    aik_front u_front (
        .aclk       (aclk),
        .adv        (adv),
        .target_x   (s_target_x),
        .target_y   (s_target_y),
        .seg_length (seg_length_reg),
        .x_out      (fx),
        .y_out      (fy),
        .s_out      (fs),
        .d_out      (fd),
        .far_out    (ffar)
    );

    aik_cordic u_base_cordic (
        .aclk  (aclk),
        .adv   (adv),
        .x_in  (aik_pkg::CW'(fx)),
        .y_in  (aik_pkg::CW'(fy)),
        .z_out (zb)
    );

    aik_isqrt u_sqrt_adj (
        .aclk  (aclk),
        .adv   (adv),
        .value (fs),
        .root  (adj)
    );

    aik_isqrt u_sqrt_opp (
        .aclk  (aclk),
        .adv   (adv),
        .value (fd),
        .root  (opp)
    );

    aik_cordic u_theta_cordic (
        .aclk  (aclk),
        .adv   (adv),
        .x_in  (aik_pkg::CW'({1'b0, adj})),
        .y_in  (aik_pkg::CW'({1'b0, opp})),
        .z_out (zt)
    );

    // align the base angle and reach flag with the shoulder angle
    always_ff @(posedge aclk) begin
        if (adv) begin
            zb_dly_reg[0]  <= zb;
            far_dly_reg[0] <= ffar;
            for (int i = 1; i < ZB_DLY; i++) begin
                zb_dly_reg[i] <= zb_dly_reg[i-1];
            end
            for (int i = 1; i < FAR_DLY; i++) begin
                far_dly_reg[i] <= far_dly_reg[i-1];
            end
        end
    end

    always_comb begin
        if (far_dly_reg[FAR_DLY-1] || zt < 0) begin
            theta = '0;
        end else if (zt > aik_pkg::DEG90) begin
            theta = aik_pkg::DEG90;
        end else begin
            theta = zt;
        end
        base_full  = aik_pkg::DEG180 + zb_dly_reg[ZB_DLY-1];
        elbow_full = (aik_pkg::DEG90 - theta) <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            base_angle_reg <= 9'(base_full >>> aik_pkg::FRAC_BITS);
            shoulder_reg   <= aik_pkg::SHOULDER_BASE - 8'(theta >>> aik_pkg::FRAC_BITS);
            elbow_reg      <= aik_pkg::ELBOW_BASE + 9'(elbow_full >>> aik_pkg::FRAC_BITS);
            far_reg        <= far_dly_reg[FAR_DLY-1];
        end
    end

    assign m_valid            = vld_reg[LAT-1];
    assign m_base_angle       = base_angle_reg;
    assign m_shoulder_command = shoulder_reg;
    assign m_elbow_command    = elbow_reg;
    assign m_out_of_reach     = far_reg;

endmodule

// ===== hdl/aik_front.sv =====
// Front stages: squares of the target coordinates, reach test and remaining radicand.
module aik_front (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic signed [31:0]            target_x,
    input  logic signed [31:0]            target_y,
    input  logic [aik_pkg::LEN_W-1:0]     seg_length,
    output logic signed [31:0]            x_out,
    output logic signed [31:0]            y_out,
    output logic [63:0]                   s_out,
    output logic [63:0]                   d_out,
    output logic                          far_out
);

    logic [31:0] ax;
    logic [31:0] ay;

    logic signed [31:0] x1_reg, x2_reg, x3_reg;
    logic signed [31:0] y1_reg, y2_reg, y3_reg;
    logic [63:0] sqx_reg, sqy_reg;
    logic [61:0] ll_reg;
    logic [63:0] s2_reg, q2_reg;
    logic [63:0] s3_reg, d3_reg;
    logic        far3_reg;

    assign ax = target_x[31] ? (~target_x + 32'd1) : target_x;
    assign ay = target_y[31] ? (~target_y + 32'd1) : target_y;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg   <= target_x;
            y1_reg   <= target_y;
            sqx_reg  <= 64'(ax) * 64'(ax);
            sqy_reg  <= 64'(ay) * 64'(ay);
            ll_reg   <= 62'(seg_length) * 62'(seg_length);

            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            s2_reg   <= sqx_reg + sqy_reg;
            q2_reg   <= {ll_reg, 2'b00};

            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            s3_reg   <= s2_reg;
            far3_reg <= s2_reg > q2_reg;
            d3_reg   <= (s2_reg > q2_reg) ? 64'd0 : (q2_reg - s2_reg);
        end
    end

    assign x_out   = x3_reg;
    assign y_out   = y3_reg;
    assign s_out   = s3_reg;
    assign d_out   = d3_reg;
    assign far_out = far3_reg;

endmodule

// ===== hdl/aik_isqrt.sv =====
// Pipelined floor square root of a 64-bit value, one root bit per stage.
module aik_isqrt (
    input  logic        aclk,
    input  logic        adv,
    input  logic [63:0] value,
    output logic [31:0] root
);

    localparam int RW = 34;

    logic [63:0]   rad_reg  [aik_pkg::ISQ_STEPS];
    logic [RW-1:0] rem_reg  [aik_pkg::ISQ_STEPS];
    logic [31:0]   root_reg [aik_pkg::ISQ_STEPS];

    for (genvar k = 0; k < aik_pkg::ISQ_STEPS; k++) begin : g_stage
        logic [63:0]   rad_in;
        logic [RW-1:0] rem_in;
        logic [31:0]   root_in;
        logic [RW-1:0] shifted;
        logic [RW-1:0] trial;

        if (k == 0) begin : g_first
            assign rad_in  = value;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two radicand bits
        assign shifted = {rem_in[RW-3:0], rad_in[63:62]};
        assign trial   = {root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[k] <= {rad_in[61:0], 2'b00};
                if (shifted >= trial) begin
                    rem_reg[k]  <= shifted - trial;
                    root_reg[k] <= {root_in[30:0], 1'b1};
                end else begin
                    rem_reg[k]  <= shifted;
                    root_reg[k] <= {root_in[30:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[aik_pkg::ISQ_STEPS-1];

endmodule

// ===== hdl/aik_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in degrees, one micro-rotation per stage.
module aik_cordic (
    input  logic                              aclk,
    input  logic                              adv,
    input  logic signed [aik_pkg::CW-1:0]     x_in,
    input  logic signed [aik_pkg::CW-1:0]     y_in,
    output logic signed [aik_pkg::ZW-1:0]     z_out
);

    aik_pkg::cordic_st_t st_reg [aik_pkg::CORDIC_STEPS+1];
    aik_pkg::cordic_st_t pre;
    logic signed [aik_pkg::ZW-1:0] z_reg;
    aik_pkg::cordic_st_t last;

    // axis targets are exact; left half plane turns by 180 degrees first
    always_comb begin
        pre.x      = x_in;
        pre.y      = y_in;
        pre.z      = '0;
        pre.fixed  = (y_in == '0) || (x_in == '0);
        if (y_in == '0) begin
            pre.fixval = x_in[aik_pkg::CW-1] ? aik_pkg::DEG180 : '0;
        end else begin
            pre.fixval = (y_in > 0) ? aik_pkg::DEG90 : -aik_pkg::DEG90;
        end
        if (x_in[aik_pkg::CW-1]) begin
            pre.x = -x_in;
            pre.y = -y_in;
            pre.z = (y_in > 0) ? aik_pkg::DEG180 : -aik_pkg::DEG180;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= pre;
        end
    end

    for (genvar i = 0; i < aik_pkg::CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [aik_pkg::ZW-1:0] ANG = aik_pkg::atan_entry(i);
        aik_pkg::cordic_st_t cur;
        aik_pkg::cordic_st_t nxt;
        logic signed [aik_pkg::CW-1:0] xs;
        logic signed [aik_pkg::CW-1:0] ys;

        assign cur = st_reg[i];
        assign xs  = cur.x >>> i;
        assign ys  = cur.y >>> i;

        always_comb begin
            nxt = cur;
            if (cur.y < 0) begin
                nxt.x = cur.x - ys;
                nxt.y = cur.y + xs;
                nxt.z = cur.z - ANG;
            end else begin
                nxt.x = cur.x + ys;
                nxt.y = cur.y - xs;
                nxt.z = cur.z + ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[i+1] <= nxt;
            end
        end
    end

    assign last = st_reg[aik_pkg::CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (last.fixed) begin
                z_reg <= last.fixval;
            end else if (last.z > aik_pkg::DEG180) begin
                z_reg <= aik_pkg::DEG180;
            end else if (last.z < -aik_pkg::DEG180) begin
                z_reg <= -aik_pkg::DEG180;
            end else begin
                z_reg <= last.z;
            end
        end
    end

    assign z_out = z_reg;

endmodule

// ===== bench/aik_checker.sv =====
// Checker for the arm inverse kinematics block: predicts joint commands and compares results.
module aik_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [aik_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [31:0]        s_target_x,
    input  logic signed [31:0]        s_target_y,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [8:0]                m_base_angle,
    input  logic [7:0]                m_shoulder_command,
    input  logic [8:0]                m_elbow_command,
    input  logic                      m_out_of_reach,
    output int                        err_count,
    output int                        pending,
    output int                        far_seen
);

    typedef struct packed {
        logic [8:0] base;
        logic [7:0] shoulder;
        logic [8:0] elbow;
        logic       far;
    } joints_t;

    localparam longint ONE = longint'(1) <<< aik_pkg::FRAC_BITS;

    joints_t                   joints_q[$];
    logic [aik_pkg::LEN_W-1:0] seg_len;

    function automatic longint turn_entry(input int i);
        longint t;
        t = aik_pkg::ATAN_Q24[i];
        if (aik_pkg::TBL_SH == 0) return t;
        return (t + (longint'(1) <<< (aik_pkg::TBL_SH - 1))) >>> aik_pkg::TBL_SH;
    endfunction

    function automatic longint heading(input longint x, input longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (y == 0) return (x < 0) ? 180 * ONE : 0;
        if (x == 0) return (y > 0) ? 90 * ONE : -90 * ONE;
        if (x < 0) begin
            z = (y > 0) ? 180 * ONE : -180 * ONE;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < aik_pkg::CORDIC_STEPS && i < aik_pkg::TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - turn_entry(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + turn_entry(i);
            end
        end
        if (z > 180 * ONE) z = 180 * ONE;
        if (z < -180 * ONE) z = -180 * ONE;
        return z;
    endfunction

    function automatic longint floor_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic joints_t solve_joints(input logic signed [31:0] tx,
                                             input logic signed [31:0] ty);
        longint      x;
        longint      y;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] s;
        logic [63:0] q;
        longint      base;
        longint      theta;
        longint      elbow;
        joints_t     j;
        x = tx;
        y = ty;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        s = ax * ax + ay * ay;
        q = 4 * ({33'd0, seg_len} * {33'd0, seg_len});
        j.far = s > q;
        base = 180 * ONE + heading(x, y);
        if (base < 0) base = 0;
        if (base > 360 * ONE) base = 360 * ONE;
        if (j.far) begin
            theta = 0;
        end else begin
            theta = heading(floor_root(s), floor_root(q - s));
            if (theta < 0) theta = 0;
            if (theta > 90 * ONE) theta = 90 * ONE;
        end
        elbow = 2 * (90 * ONE - theta);
        j.base = 9'(base >>> aik_pkg::FRAC_BITS);
        j.shoulder = 8'(170 - (theta >>> aik_pkg::FRAC_BITS));
        j.elbow = 9'(120 + (elbow >>> aik_pkg::FRAC_BITS));
        return j;
    endfunction

    always @(posedge aclk) begin
        joints_t want;
        joints_t got;
        if (!aresetn) begin
            seg_len <= aik_pkg::SEG_LENGTH_RESET;
            joints_q.delete();
            err_count <= 0;
            far_seen <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) seg_len <= cfg_wdata;
            if (s_valid && s_ready) joints_q.push_back(solve_joints(s_target_x, s_target_y));
            if (m_valid && m_ready) begin
                got = '{m_base_angle, m_shoulder_command, m_elbow_command, m_out_of_reach};
                if (joints_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    err_count <= err_count + 1;
                end else begin
                    want = joints_q.pop_front();
                    if (got.far) far_seen <= far_seen + 1;
                    if (got != want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        err_count <= err_count + 1;
                    end
                end
            end
            pending <= joints_q.size();
        end
    end
endmodule

// ===== bench/tb.sv =====
// Testbench top: drives targets and arm length settings, and reports the verdict.
module tb;

    logic                        aclk = 0;
    logic                        aresetn = 0;
    logic                        cfg_we = 0;
    logic [aik_pkg::LEN_W-1:0]   cfg_wdata = 0;
    logic                        s_valid = 0;
    logic                        s_ready;
    logic signed [31:0]          s_target_x = 0;
    logic signed [31:0]          s_target_y = 0;
    logic                        m_valid;
    logic                        m_ready = 0;
    logic [8:0]                  m_base_angle;
    logic [7:0]                  m_shoulder_command;
    logic [8:0]                  m_elbow_command;
    logic                        m_out_of_reach;
    int                          err_count;
    int                          pending;
    int                          far_seen;
    int                          send_idle_pct;
    int                          recv_idle_pct;
    int                          idle_cycles;
    int                          sent;

    localparam int WATCHDOG = 20000;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    arm_inverse_kinematics_top dut (.*);
    aik_checker chk (.*);

    // receiver stalls at random
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog timeout");
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // valid stays high from one item to the next unless the sender idles
    task automatic send_target(input logic signed [31:0] x, input logic signed [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_target_x <= x;
        s_target_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (aik_pkg::TOTAL_LAT + 10) @(negedge aclk);
    endtask

    task automatic set_length(input logic [aik_pkg::LEN_W-1:0] len);
        drain();
        cfg_we <= 1;
        cfg_wdata <= len;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // mostly targets near reach for the current length, some full range
    task automatic random_targets(input int n, input logic [aik_pkg::LEN_W-1:0] len);
        logic signed [31:0] x;
        logic signed [31:0] y;
        longint             r;
        repeat (n) begin
            r = 3 * longint'(len);
            if (r > 32'h7fff_ffff) r = 32'h7fff_ffff;
            if ($urandom_range(3) == 0) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = 32'($urandom_range(32'(r)));
                y = 32'($urandom_range(32'(r)));
                if ($urandom_range(1)) x = -x;
                if ($urandom_range(1)) y = -y;
                if ($urandom_range(9) == 0) x = 0;
                if ($urandom_range(9) == 0) y = 0;
            end
            send_target(x, y);
        end
    endtask

    initial begin
        logic [aik_pkg::LEN_W-1:0] lens [5];
        lens = '{31'd65536, 31'd1, 31'h7fff_ffff, 31'd0, 31'd300000};
        send_idle_pct = 29;
        recv_idle_pct = 70;
        sent = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // axes, origin, quadrants, extremes, reach boundary at default length
        send_target(0, 0);
        send_target(32'sd65536, 0);
        send_target(-32'sd65536, 0);
        send_target(0, 32'sd65536);
        send_target(0, -32'sd65536);
        send_target(32'sd65536, 32'sd65536);
        send_target(-32'sd65536, 32'sd65536);
        send_target(-32'sd65536, -32'sd65536);
        send_target(32'sd65536, -32'sd65536);
        send_target(32'sd131072, 0);
        send_target(32'sd131073, 0);
        send_target(32'h7fffffff, 32'h7fffffff);
        send_target(32'h80000000, 32'h80000000);
        send_target(32'h80000000, 0);
        send_target(0, 32'h80000000);
        send_target(32'h7fffffff, 32'h80000000);
        send_target(-1, 1);
        send_target(-1, -1);
        send_target(1, 0);
        send_target(32'h55555555, 32'haaaaaaaa);
        for (int i = 0; i < 5; i++) begin
            if (i == 2) begin
                send_idle_pct = 70;
                recv_idle_pct = 29;
            end
            if (i == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_length(lens[i]);
            send_target(0, 0);
            send_target(32'(2 * longint'(lens[i])), 0);
            random_targets(155, lens[i]);
        end
        drain();
        $display("Sent %0d targets over five arm lengths including 0, 1 and the maximum;",
                 sent);
        $display("%0d results were out of reach.", far_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/aik_pkg.sv
hdl/aik_front.sv
hdl/aik_isqrt.sv
hdl/aik_cordic.sv
hdl/arm_inverse_kinematics_top.sv
bench/aik_checker.sv
bench/tb.sv
